// ----- rtl/core/eaa_pkg.sv -----
package eaa_pkg;

    localparam int MAX_CH    = 4;
    localparam int MAX_TG    = 8;
    localparam int EPOCH_LEN = 1024;
    localparam int SMP_W     = 16;
    localparam int SUM_W     = 32;
    localparam int CNTS_W    = 16;
    localparam int TG_W      = $clog2(MAX_TG);
    localparam int TGC_W     = $clog2(MAX_TG + 1);
    localparam int POS_W     = $clog2(EPOCH_LEN);
    localparam int LEN_W     = $clog2(EPOCH_LEN + 1);
    localparam int ADDR_W    = TG_W + POS_W;
    localparam int CODE_W    = 8;
    localparam int CFG_W     = 3;
    localparam int CHS_W     = 2;
    localparam int RANK_W    = 3;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(2);

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FOLDED  = 2'd1,
        ST_DROPPED = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        logic in_open;
        logic clr_step;
        logic sample;
        logic fold_look;
        logic fold_rd;
        logic fold_wr;
        logic fold_end;
        logic scan_step;
        logic rank_step;
        logic mem_rd;
        logic div_start;
        logic div_take;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic accept;
        logic clr_done;
        logic kind;
        logic code_zero;
        logic prev_zero;
        logic table_full_miss;
        logic run_empty;
        logic fold_last;
        logic idx_last;
        logic rd_ok;
        logic cnt_zero;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

// ----- rtl/core/eaa_div.sv -----
module eaa_div
    import eaa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SUM_W-1:0]  i_dividend,
    input  logic [CNTS_W-1:0] i_divisor,
    output logic              o_done,
    output logic [SUM_W-1:0]  o_quotient
);

    localparam int STEP_W = $clog2(SUM_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CNTS_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_quo;
    logic [CNTS_W-1:0] r_dvs;
    logic [CNTS_W:0]   rem_sh;
    logic              fits;

    // one quotient bit per cycle, restoring
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? CNTS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[CNTS_W-1:0];
            r_quo <= {r_quo[SUM_W-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ----- rtl/core/eaa_ctrl.sv -----
module eaa_ctrl
    import eaa_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_st,
    output t_cmd  o_cmd
);

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_EXEC      = 13'b0000000000100,
        S_FOLD_LOOK = 13'b0000000001000,
        S_FOLD_RD   = 13'b0000000010000,
        S_FOLD_WR   = 13'b0000000100000,
        S_FOLD_END  = 13'b0000001000000,
        S_SCAN      = 13'b0000010000000,
        S_RANK      = 13'b0000100000000,
        S_RD_MEM    = 13'b0001000000000,
        S_RD_WAIT   = 13'b0010000000000,
        S_DIV       = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_st.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.in_open = 1'b1;
                if (i_st.accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_st.kind) begin
                    n_state = S_RANK;
                end else if (i_st.code_zero && !i_st.prev_zero) begin
                    n_state = S_FOLD_LOOK;
                end else begin
                    o_cmd.sample = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_FOLD_LOOK: begin
                o_cmd.fold_look = 1'b1;
                if (i_st.table_full_miss) n_state = S_DONE;
                else if (i_st.run_empty)  n_state = S_FOLD_END;
                else                      n_state = S_FOLD_RD;
            end
            S_FOLD_RD: begin
                o_cmd.fold_rd = 1'b1;
                n_state = S_FOLD_WR;
            end
            S_FOLD_WR: begin
                o_cmd.fold_wr = 1'b1;
                n_state = i_st.fold_last ? S_FOLD_END : S_FOLD_RD;
            end
            S_FOLD_END: begin
                o_cmd.fold_end = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_st.idx_last) n_state = S_DONE;
            end
            S_RANK: begin
                o_cmd.rank_step = 1'b1;
                if (i_st.idx_last) n_state = S_RD_MEM;
            end
            S_RD_MEM: begin
                if (i_st.rd_ok) begin
                    o_cmd.mem_rd = 1'b1;
                    n_state = S_RD_WAIT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_RD_WAIT: begin
                if (i_st.cnt_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_st.div_done) begin
                    o_cmd.div_take = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

endmodule

// ----- rtl/core/eaa_dp.sv -----
module eaa_dp
    import eaa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_cmd                     i_cmd,
    output t_stat                    o_st,
    input  logic                     i_cfg_valid,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    input  logic                     i_kind,
    input  logic [CODE_W-1:0]        i_target_code,
    input  logic signed [SMP_W-1:0]  i_sample_ch0,
    input  logic signed [SMP_W-1:0]  i_sample_ch1,
    input  logic signed [SMP_W-1:0]  i_sample_ch2,
    input  logic signed [SMP_W-1:0]  i_sample_ch3,
    input  logic [RANK_W-1:0]        i_read_rank,
    input  logic [CHS_W-1:0]         i_read_channel,
    input  logic [POS_W-1:0]         i_read_position,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output logic [1:0]               o_status,
    output logic [TGC_W-1:0]         o_known_targets,
    output logic [CODE_W-1:0]        o_read_code,
    output logic signed [SMP_W-1:0]  o_average,
    output logic                     o_read_valid,
    output logic [LEN_W-1:0]         o_common_length
);

    typedef logic [MAX_CH-1:0][SMP_W-1:0] t_smp_row;
    typedef logic [MAX_CH-1:0][SUM_W-1:0] t_sum_row;

    // memories
    t_smp_row          buf_mem [EPOCH_LEN];
    logic [CNTS_W-1:0] cnt_mem [1 << ADDR_W];
    t_sum_row          sum_mem [1 << ADDR_W];

    logic [CFG_W-1:0]  r_cfg;
    logic              r_kind;
    logic [CODE_W-1:0] r_code;
    t_smp_row          r_smp;
    logic [RANK_W-1:0] r_rank;
    logic [CHS_W-1:0]  r_ch;
    logic [POS_W-1:0]  r_pos;

    logic [CODE_W-1:0] r_prev;
    logic [LEN_W-1:0]  r_run_len;
    logic [TGC_W-1:0]  r_tcount;
    logic [CODE_W-1:0] r_code_tab [MAX_TG];
    logic [LEN_W-1:0]  r_tlen [MAX_TG];
    logic [LEN_W-1:0]  r_common;

    logic [ADDR_W-1:0] r_clr_addr;
    logic [TG_W-1:0]   r_slot;
    logic [POS_W-1:0]  r_p;
    logic [TG_W-1:0]   r_idx;
    logic              r_found;

    t_smp_row          r_buf_q;
    logic [CNTS_W-1:0] r_cnt_q;
    t_sum_row          r_sum_q;

    t_status           r_status;
    logic [CODE_W-1:0] r_rcode;
    logic [SMP_W-1:0]  r_avg;
    logic              r_rvalid;

    logic              r_out_valid;
    t_status           r_o_status;
    logic [TGC_W-1:0]  r_o_known;
    logic [CODE_W-1:0] r_o_rcode;
    logic [SMP_W-1:0]  r_o_avg;
    logic              r_o_rvalid;
    logic [LEN_W-1:0]  r_o_common;

    logic              accept;
    logic [CFG_W-1:0]  nch;
    logic              hit;
    logic [TG_W-1:0]   hit_slot;
    logic [TGC_W-1:0]  below;
    logic              idx_used;
    logic              buf_full;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [CNTS_W-1:0] cnt_new;
    t_sum_row          sum_new;
    logic [SUM_W:0]    sum_ext;
    logic [SUM_W-1:0]  sel_sum;
    logic              sel_neg;
    logic [SUM_W-1:0]  mag;
    logic              div_done;
    logic [SUM_W-1:0]  quo;
    logic [SMP_W-1:0]  avg_sat;

    assign accept = i_cmd.in_open & i_in_valid;

    always_comb begin
        if (r_cfg == '0)                      nch = CFG_W'(1);
        else if (r_cfg > CFG_W'(MAX_CH))      nch = CFG_W'(MAX_CH);
        else                                  nch = r_cfg;
    end

    // code lookup over the table
    always_comb begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int t = 0; t < MAX_TG; t++) begin
            if (TGC_W'(t) < r_tcount && r_code_tab[t] == r_prev) begin
                hit      = 1'b1;
                hit_slot = TG_W'(t);
            end
        end
    end

    // number of known codes below the code at r_idx
    always_comb begin
        below = '0;
        for (int u = 0; u < MAX_TG; u++) begin
            if (TGC_W'(u) < r_tcount && r_code_tab[u] < r_code_tab[r_idx]) begin
                below = below + TGC_W'(1);
            end
        end
    end

    assign idx_used = {1'b0, r_idx} < r_tcount;
    assign buf_full = r_run_len >= LEN_W'(EPOCH_LEN);

    assign rd_addr = {r_slot, (i_cmd.mem_rd ? r_pos : r_p)};
    assign wr_addr = i_cmd.clr_step ? r_clr_addr : {r_slot, r_p};
    assign rd_en   = i_cmd.fold_rd | i_cmd.mem_rd;

    assign cnt_new = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + CNTS_W'(1);

    always_comb begin
        sum_new = r_sum_q;
        sum_ext = '0;
        for (int c = 0; c < MAX_CH; c++) begin
            sum_ext = {r_sum_q[c][SUM_W-1], r_sum_q[c]}
                    + {{(SUM_W + 1 - SMP_W){r_buf_q[c][SMP_W-1]}}, r_buf_q[c]};
            if (CFG_W'(c) < nch) begin
                if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
                    sum_new[c] = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                    sum_new[c] = sum_ext[SUM_W-1:0];
                end
            end
        end
    end

    assign sel_sum = r_sum_q[r_ch];
    assign sel_neg = sel_sum[SUM_W-1];
    assign mag     = sel_neg ? (~sel_sum + SUM_W'(1)) : sel_sum;

    eaa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (mag),
        .i_divisor  (r_cnt_q),
        .o_done     (div_done),
        .o_quotient (quo)
    );

    always_comb begin
        if (!sel_neg) begin
            avg_sat = (quo > SUM_W'((1 << (SMP_W - 1)) - 1))
                    ? {1'b0, {(SMP_W-1){1'b1}}} : quo[SMP_W-1:0];
        end else begin
            avg_sat = (quo > SUM_W'(1 << (SMP_W - 1)))
                    ? {1'b1, {(SMP_W-1){1'b0}}} : SMP_W'(~quo + SUM_W'(1));
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.sample && r_code != '0 && !buf_full) begin
            buf_mem[r_run_len[POS_W-1:0]] <= r_smp;
        end
        if (i_cmd.fold_rd) begin
            r_buf_q <= buf_mem[r_p];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || i_cmd.fold_wr) begin
            cnt_mem[wr_addr] <= i_cmd.clr_step ? '0 : cnt_new;
        end
        if (rd_en) begin
            r_cnt_q <= cnt_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step || i_cmd.fold_wr) begin
            sum_mem[wr_addr] <= i_cmd.clr_step ? '0 : sum_new;
        end
        if (rd_en) begin
            r_sum_q <= sum_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg       <= CFG_RESET;
            r_prev      <= '0;
            r_run_len   <= '0;
            r_tcount    <= '0;
            r_common    <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            for (int t = 0; t < MAX_TG; t++) r_tlen[t] <= '0;
        end else begin
            if (i_cfg_valid) r_cfg <= i_cfg_data;
            if (i_cmd.clr_step) r_clr_addr <= r_clr_addr + ADDR_W'(1);

            if (i_cmd.sample) begin
                r_prev <= r_code;
                if (r_code != '0 && !buf_full) r_run_len <= r_run_len + LEN_W'(1);
            end

            if (i_cmd.fold_look) begin
                if (!hit && r_tcount >= TGC_W'(MAX_TG)) begin
                    r_run_len <= '0;
                    r_prev    <= '0;
                end else if (!hit) begin
                    r_tlen[r_tcount[TG_W-1:0]] <= '0;
                    r_tcount <= r_tcount + TGC_W'(1);
                end
            end

            if (i_cmd.fold_end) begin
                if (r_run_len > r_tlen[r_slot]) r_tlen[r_slot] <= r_run_len;
                r_run_len <= '0;
                r_prev    <= '0;
            end

            if (i_cmd.scan_step && idx_used) begin
                if (r_idx == '0 || r_tlen[r_idx] < r_common) r_common <= r_tlen[r_idx];
            end

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_code   <= i_target_code;
            r_smp    <= {i_sample_ch3, i_sample_ch2, i_sample_ch1, i_sample_ch0};
            r_rank   <= i_read_rank;
            r_ch     <= i_read_channel;
            r_pos    <= i_read_position;
            r_status <= ST_OK;
            r_rcode  <= '0;
            r_avg    <= '0;
            r_rvalid <= 1'b0;
            r_idx    <= '0;
            r_found  <= 1'b0;
        end
        if (i_cmd.sample && r_code != '0 && buf_full) r_status <= ST_DROPPED;
        if (i_cmd.fold_look) begin
            r_p <= '0;
            if (hit) begin
                r_slot <= hit_slot;
            end else if (r_tcount >= TGC_W'(MAX_TG)) begin
                r_status <= ST_FULL;
            end else begin
                r_slot <= r_tcount[TG_W-1:0];
                r_code_tab[r_tcount[TG_W-1:0]] <= r_prev;
            end
        end
        if (i_cmd.fold_wr) r_p <= r_p + POS_W'(1);
        if (i_cmd.fold_end) begin
            r_status <= ST_FOLDED;
            r_idx    <= '0;
        end
        if (i_cmd.scan_step || i_cmd.rank_step) r_idx <= r_idx + TG_W'(1);
        if (i_cmd.rank_step && idx_used && below == {1'b0, r_rank}) begin
            r_found <= 1'b1;
            r_slot  <= r_idx;
            r_rcode <= r_code_tab[r_idx];
        end
        if (i_cmd.div_take) begin
            r_avg    <= avg_sat;
            r_rvalid <= 1'b1;
        end
        if (i_cmd.out_load) begin
            r_o_status <= r_status;
            r_o_known  <= r_tcount;
            r_o_rcode  <= r_rcode;
            r_o_avg    <= r_avg;
            r_o_rvalid <= r_rvalid;
            r_o_common <= r_common;
        end
    end

    assign o_st.accept          = accept;
    assign o_st.clr_done        = r_clr_addr == '1;
    assign o_st.kind            = r_kind;
    assign o_st.code_zero       = r_code == '0;
    assign o_st.prev_zero       = r_prev == '0;
    assign o_st.table_full_miss = !hit && r_tcount >= TGC_W'(MAX_TG);
    assign o_st.run_empty       = r_run_len == '0;
    assign o_st.fold_last       = ({1'b0, r_p} + LEN_W'(1)) >= r_run_len;
    assign o_st.idx_last        = r_idx == TG_W'(MAX_TG - 1);
    assign o_st.rd_ok           = r_found && ({1'b0, r_ch} < nch)
                                  && ({1'b0, r_pos} < r_common);
    assign o_st.cnt_zero        = r_cnt_q == '0;
    assign o_st.div_done        = div_done;
    assign o_st.out_free        = !r_out_valid || !i_out_stall;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_known_targets = r_o_known;
    assign o_read_code     = r_o_rcode;
    assign o_average       = r_o_avg;
    assign o_read_valid    = r_o_rvalid;
    assign o_common_length = r_o_common;

endmodule

// ----- rtl/core/epoch_average_accumulator_top.sv -----
// Event-related epoch averaging.
// Input channel (i_in_valid / o_in_stall): one item per time point or read.
//   A sample item buffers up to four channel samples while its target code is
//   nonzero; a zero code after a run folds the run into per-target sums.
//   A read item returns sum/count for a target rank, channel and position.
// Output channel (o_out_valid / i_out_stall): exactly one result per item.
// Config channel (i_cfg_valid / o_cfg_ready): channels in use, always ready.
// Flow: one item at a time. A fold does one read-modify-write of the sum
//   and count memories per buffered position; a read item runs the 8-step
//   rank scan and, when the read is in range with a nonzero count, the
//   bit-serial divider.
// Reset: synchronous, active low. After reset a clearing pass writes zero
//   to all 8192 rows of the sum and count memories; o_in_stall stays high
//   until that pass ends.
// A stalled result holds in the output register; the next item is accepted
//   and processed meanwhile, and its result waits until the register frees.
module epoch_average_accumulator_top
    import eaa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_kind,
    input  logic [CODE_W-1:0]        i_target_code,
    input  logic signed [SMP_W-1:0]  i_sample_ch0,
    input  logic signed [SMP_W-1:0]  i_sample_ch1,
    input  logic signed [SMP_W-1:0]  i_sample_ch2,
    input  logic signed [SMP_W-1:0]  i_sample_ch3,
    input  logic [RANK_W-1:0]        i_read_rank,
    input  logic [CHS_W-1:0]         i_read_channel,
    input  logic [POS_W-1:0]         i_read_position,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [1:0]               o_status,
    output logic [TGC_W-1:0]         o_known_targets,
    output logic [CODE_W-1:0]        o_read_code,
    output logic signed [SMP_W-1:0]  o_average,
    output logic                     o_read_valid,
    output logic [LEN_W-1:0]         o_common_length
);

    t_cmd  cmd;
    t_stat st;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !cmd.in_open;

    eaa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    eaa_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_kind          (i_kind),
        .i_target_code   (i_target_code),
        .i_sample_ch0    (i_sample_ch0),
        .i_sample_ch1    (i_sample_ch1),
        .i_sample_ch2    (i_sample_ch2),
        .i_sample_ch3    (i_sample_ch3),
        .i_read_rank     (i_read_rank),
        .i_read_channel  (i_read_channel),
        .i_read_position (i_read_position),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_known_targets (o_known_targets),
        .o_read_code     (o_read_code),
        .o_average       (o_average),
        .o_read_valid    (o_read_valid),
        .o_common_length (o_common_length)
    );

endmodule

// ----- verif/tb_epoch_average_accumulator_top.sv -----
module tb_epoch_average_accumulator_top;
    import eaa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 60000;

    typedef struct {
        logic              kind;
        logic [CODE_W-1:0] code;
        logic [SMP_W-1:0]  smp [MAX_CH];
        logic [RANK_W-1:0] rank;
        logic [CHS_W-1:0]  chan;
        logic [POS_W-1:0]  pos;
    } t_item;

    typedef struct {
        t_status           status;
        logic [TGC_W-1:0]  known;
        logic [CODE_W-1:0] rcode;
        logic [SMP_W-1:0]  avg;
        logic              rvalid;
        logic [LEN_W-1:0]  clen;
    } t_result;

    class epoch_scoreboard;
        logic [CFG_W-1:0]  ch_reg = CFG_RESET;
        logic [CODE_W-1:0] prev_code = '0;
        int                run_len = 0;
        logic [SMP_W-1:0]  run_buf [MAX_CH][EPOCH_LEN];
        int                n_targets = 0;
        logic [CODE_W-1:0] codes [MAX_TG];
        int                tlen [MAX_TG];
        int                cnt [MAX_TG][EPOCH_LEN];
        int                sums [MAX_CH][MAX_TG][EPOCH_LEN];
        t_result           pending [$];
        int                errors = 0;

        function new();
            foreach (tlen[t]) tlen[t] = 0;
            foreach (cnt[t, p]) cnt[t][p] = 0;
            foreach (sums[c, t, p]) sums[c][t][p] = 0;
        endfunction

        function int n_active();
            if (ch_reg == 0) return 1;
            if (ch_reg > MAX_CH) return MAX_CH;
            return ch_reg;
        endfunction

        function int shortest_len();
            int m;
            m = 0;
            for (int t = 0; t < n_targets; t++)
                if (t == 0 || tlen[t] < m) m = tlen[t];
            return m;
        endfunction

        function t_status fold_run();
            int     slot;
            longint s;
            slot = MAX_TG;
            for (int t = 0; t < n_targets; t++)
                if (codes[t] == prev_code) slot = t;
            if (slot == MAX_TG) begin
                if (n_targets >= MAX_TG) begin
                    run_len = 0;
                    return ST_FULL;
                end
                slot = n_targets;
                codes[slot] = prev_code;
                tlen[slot] = 0;
                n_targets++;
            end
            for (int p = 0; p < run_len; p++) begin
                if (cnt[slot][p] < 65535) cnt[slot][p]++;
                for (int c = 0; c < n_active(); c++) begin
                    s = longint'(sums[c][slot][p]) + longint'($signed(run_buf[c][p]));
                    if (s > 64'sd2147483647) s = 64'sd2147483647;
                    if (s < -64'sd2147483648) s = -64'sd2147483648;
                    sums[c][slot][p] = int'(s);
                end
            end
            if (run_len > tlen[slot]) tlen[slot] = run_len;
            run_len = 0;
            return ST_FOLDED;
        endfunction

        function void note_item(t_item it);
            t_result r;
            int      slot, below;
            longint  a;
            r.status = ST_OK;
            r.rcode = '0;
            r.avg = '0;
            r.rvalid = 1'b0;
            if (it.kind == 1'b0) begin
                if (it.code == 0) begin
                    if (prev_code != 0) r.status = fold_run();
                end else if (run_len < EPOCH_LEN) begin
                    for (int c = 0; c < MAX_CH; c++) run_buf[c][run_len] = it.smp[c];
                    run_len++;
                end else begin
                    r.status = ST_DROPPED;
                end
                prev_code = it.code;
            end else begin
                slot = MAX_TG;
                for (int t = 0; t < n_targets; t++) begin
                    below = 0;
                    for (int u = 0; u < n_targets; u++)
                        if (codes[u] < codes[t]) below++;
                    if (below == it.rank) slot = t;
                end
                if (slot < MAX_TG) begin
                    r.rcode = codes[slot];
                    if (it.chan < n_active() && it.pos < shortest_len()
                            && cnt[slot][it.pos] != 0) begin
                        a = longint'(sums[it.chan][slot][it.pos]) / longint'(cnt[slot][it.pos]);
                        if (a > 32767) a = 32767;
                        if (a < -32768) a = -32768;
                        r.avg = a[SMP_W-1:0];
                        r.rvalid = 1'b1;
                    end
                end
            end
            r.known = n_targets[TGC_W-1:0];
            r.clen = LEN_W'(shortest_len());
            pending.insert(pending.size(), r);
        endfunction

        task report(string what, longint got, longint want);
            $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
            errors++;
        endtask

        task check_result(t_result got);
            t_result w;
            if (pending.size() == 0) begin
                report("result with no item outstanding", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.status !== w.status) report("status", got.status, w.status);
            if (got.known !== w.known) report("known_targets", got.known, w.known);
            if (got.rcode !== w.rcode) report("read_code", got.rcode, w.rcode);
            if (got.avg !== w.avg)
                report("average", $signed(got.avg), $signed(w.avg));
            if (got.rvalid !== w.rvalid) report("read_valid", got.rvalid, w.rvalid);
            if (got.clen !== w.clen) report("common_length", got.clen, w.clen);
        endtask
    endclass

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_W-1:0]         i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic                     i_kind;
    logic [CODE_W-1:0]        i_target_code;
    logic signed [SMP_W-1:0]  i_sample_ch0;
    logic signed [SMP_W-1:0]  i_sample_ch1;
    logic signed [SMP_W-1:0]  i_sample_ch2;
    logic signed [SMP_W-1:0]  i_sample_ch3;
    logic [RANK_W-1:0]        i_read_rank;
    logic [CHS_W-1:0]         i_read_channel;
    logic [POS_W-1:0]         i_read_position;
    logic                     o_out_valid;
    logic                     i_out_stall;
    logic [1:0]               o_status;
    logic [TGC_W-1:0]         o_known_targets;
    logic [CODE_W-1:0]        o_read_code;
    logic signed [SMP_W-1:0]  o_average;
    logic                     o_read_valid;
    logic [LEN_W-1:0]         o_common_length;

    epoch_average_accumulator_top u_dut (.*);

    epoch_scoreboard sb = new();
    bit              jitter_on = 1'b1;
    int              idle_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // monitor: accepted items, config writes and results
    always @(posedge i_clk) begin
        t_item   it;
        t_result r;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) sb.ch_reg = i_cfg_data;
            if (i_in_valid && !o_in_stall) begin
                it.kind = i_kind;
                it.code = i_target_code;
                it.smp[0] = i_sample_ch0;
                it.smp[1] = i_sample_ch1;
                it.smp[2] = i_sample_ch2;
                it.smp[3] = i_sample_ch3;
                it.rank = i_read_rank;
                it.chan = i_read_channel;
                it.pos = i_read_position;
                sb.note_item(it);
            end
            if (o_out_valid && !i_out_stall) begin
                r.status = t_status'(o_status);
                r.known = o_known_targets;
                r.rcode = o_read_code;
                r.avg = o_average;
                r.rvalid = o_read_valid;
                r.clen = o_common_length;
                sb.check_result(r);
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk)
        i_out_stall = jitter_on && ($urandom_range(99) < 34);

    task automatic send(t_item it);
        @(negedge i_clk);
        while (jitter_on && $urandom_range(99) < 34) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind = it.kind;
        i_target_code = it.code;
        i_sample_ch0 = it.smp[0];
        i_sample_ch1 = it.smp[1];
        i_sample_ch2 = it.smp[2];
        i_sample_ch3 = it.smp[3];
        i_read_rank = it.rank;
        i_read_channel = it.chan;
        i_read_position = it.pos;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic t_item sample_item(logic [CODE_W-1:0] code);
        t_item it;
        it.kind = 1'b0;
        it.code = code;
        foreach (it.smp[c]) it.smp[c] = SMP_W'($urandom);
        it.rank = RANK_W'($urandom);
        it.chan = CHS_W'($urandom);
        it.pos = POS_W'($urandom);
        return it;
    endfunction

    function automatic t_item read_item(int rank, int chan, int pos);
        t_item it;
        it = sample_item(CODE_W'($urandom));
        it.kind = 1'b1;
        it.rank = RANK_W'(rank);
        it.chan = CHS_W'(chan);
        it.pos = POS_W'(pos);
        return it;
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_channels(logic [CFG_W-1:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_data = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_run(logic [CODE_W-1:0] code, int len);
        for (int i = 0; i < len; i++) send(sample_item(code));
        send(sample_item('0));
    endtask

    initial begin
        t_item it;
        int    n_items, code, len, r;
        bit    long_done;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_kind = 1'b0;
        i_target_code = '0;
        i_sample_ch0 = '0;
        i_sample_ch1 = '0;
        i_sample_ch2 = '0;
        i_sample_ch3 = '0;
        i_read_rank = '0;
        i_read_channel = '0;
        i_read_position = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, code change without zero, reads out of range
        write_channels(3'd4);
        it = sample_item(8'd255);
        foreach (it.smp[c]) it.smp[c] = 16'h7fff;
        send(it);
        foreach (it.smp[c]) it.smp[c] = 16'h8000;
        send(it);
        send(sample_item('0));
        send(sample_item(8'd1));
        send(sample_item(8'd1));
        send(sample_item(8'd1));
        send(sample_item(8'd9));   // folded under the last nonzero code
        send(sample_item('0));
        send(sample_item('0));     // zero after zero: nothing to fold
        send(read_item(0, 0, 0));
        send(read_item(1, 3, 1));
        send(read_item(1, 2, 2));  // beyond common length
        send(read_item(7, 3, 1023));
        send(read_item(2, 1, 0));  // rank not present
        write_channels(3'd0);
        send(read_item(0, 1, 0));
        send(read_item(0, 0, 1));
        write_channels(3'd7);
        send(read_item(1, 3, 0));
        write_channels(3'd1);

        n_items = 20;
        long_done = 1'b0;
        while (n_items < 1950) begin
            if ($urandom_range(99) < 6) write_channels(CFG_W'($urandom));
            if (n_items > 700 && n_items < 1000) jitter_on = 1'b0;
            else jitter_on = 1'b1;
            r = $urandom_range(99);
            if (!long_done && n_items > 850) begin
                // overflow run past the buffer end
                long_done = 1'b1;
                send_run(8'd200, EPOCH_LEN + 5);
                n_items += EPOCH_LEN + 6;
                wait_drained();
            end else if (r < 60) begin
                // mostly a small pool, sometimes fresh codes to fill the table
                code = ($urandom_range(9) == 0) ? $urandom_range(1, 255)
                                                : 16 * $urandom_range(1, 12);
                len = $urandom_range(1, 24);
                if ($urandom_range(4) == 0) begin
                    for (int i = 0; i < len / 2; i++) send(sample_item(CODE_W'(code)));
                    code = $urandom_range(1, 255);
                    len = len - len / 2;
                end
                send_run(CODE_W'(code), len);
                n_items += len + 1;
            end else if (r < 92) begin
                send(read_item($urandom_range(0, 7), $urandom_range(0, 3),
                    ($urandom_range(9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 30)));
                n_items++;
            end else begin
                send(sample_item(CODE_W'(($urandom_range(99) < 50) ? 0 : $urandom)));
                n_items++;
            end
        end
        write_channels(3'd4);
        for (int i = 0; i < 20; i++) begin
            send(read_item($urandom_range(0, 7), $urandom_range(0, 3), $urandom_range(0, 30)));
        end

        wait_drained();
        repeat (2200) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/eaa_pkg.sv
rtl/core/eaa_div.sv
rtl/core/eaa_ctrl.sv
rtl/core/eaa_dp.sv
rtl/core/epoch_average_accumulator_top.sv
verif/tb_epoch_average_accumulator_top.sv
